/* design/mpwa_pkg.sv */
// ----------------------------------------------------------------------------
// mpwa_pkg : shared types and constants
// Field widths, the Q1.16 unit value and the sequencer state encoding.
// ----------------------------------------------------------------------------
package mpwa_pkg;

	localparam int SCORE_W    = 17;   // Q1.16 score
	localparam int COLUMN_W   = 16;   // result column index
	localparam int HALF_W     = 6;    // half_window register
	localparam int SPAN_SHIFT = 2;    // window limit is n/4

	localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(65536);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_TAPS,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

/* design/mpwa_ifs.sv */
// ----------------------------------------------------------------------------
// mpwa_ifs : channel interfaces
// Score input, averaged result output and half-window configuration write.
// ----------------------------------------------------------------------------
interface mpwa_in_if;
	logic                         valid;
	logic                         ready;
	logic [mpwa_pkg::SCORE_W-1:0] score;
	logic                         final_column;

	modport source (output valid, output score, output final_column, input ready);
	modport sink   (input valid, input score, input final_column, output ready);
endinterface

interface mpwa_out_if;
	logic                          valid;
	logic                          ready;
	logic [mpwa_pkg::COLUMN_W-1:0] column;
	logic [mpwa_pkg::SCORE_W-1:0]  average;
	logic                          last;
	logic                          error;

	modport source (output valid, output column, output average, output last,
		output error, input ready);
	modport sink   (input valid, input column, input average, input last,
		input error, output ready);
endinterface

interface mpwa_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [mpwa_pkg::HALF_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/mirror_padded_window_average_core.sv */
// ----------------------------------------------------------------------------
// mirror_padded_window_average_core : mirror-padded boxcar average
// Windowed mean of column scores with mirrored ends, one shared
// accumulate/divide datapath under a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//  scores   : one column score word per accept (Q1.16, saturated to 1.0 on
//             entry), final_column marks the last column of a sequence.
//  averages : result words {column, average, last, error}. Column i is sent
//             once column i+h is in; the final column flushes the tail
//             (up to h+1 words), or sends one error word if h > n/4 or more
//             than MAX_COLUMNS columns came in.
//  cfg      : half_window write, always ready. Latched into the active
//             half window on the first column of each sequence.
// Sequencing
//  Each result takes a setup state, 2h+1 taps (one ring read a cycle
//  through a two-stage address/read pipe), a drain of that pipe, the
//  one-bit-per-cycle restoring divider and an output state that waits
//  while a stalled receiver holds the result register. scores is not
//  ready meanwhile; a column that yields no result is taken without the
//  sequencer leaving its idle state.
// Reset clears counters, sequencer and output valid; the ring is not
//  cleared, every slot is written before it is read.
// A stalled receiver holds the result register; the sequencer waits in its
//  output state until the register frees up.
// ----------------------------------------------------------------------------
module mirror_padded_window_average_core #(
	parameter int MAX_HALF_WINDOW = 32,
	parameter int RING_DEPTH      = 128,
	parameter int MAX_COLUMNS     = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	mpwa_in_if.sink         scores,
	mpwa_out_if.source      averages,
	mpwa_cfg_if.sink        cfg
);

	// window limited by both the parameter and the ring: 2h+1 <= RING_DEPTH
	localparam int EFF_MAX_H = (MAX_HALF_WINDOW < (RING_DEPTH - 1) / 2) ?
		MAX_HALF_WINDOW : (RING_DEPTH - 1) / 2;
	localparam int AH_W   = $clog2(EFF_MAX_H + 1);
	localparam int TAP_W  = AH_W + 1;                   // holds 2h+1
	localparam int SUM_W  = mpwa_pkg::SCORE_W + TAP_W;
	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(MAX_COLUMNS + 2);    // counts up to MAX+1
	localparam int XW     = CNT_W + 2;                  // signed tap position
	localparam int DC_W   = $clog2(SUM_W + 1);

	localparam logic [CNT_W-1:0]  MAXC      = CNT_W'(MAX_COLUMNS);
	localparam logic [CNT_W-1:0]  MAXC_P1   = CNT_W'(MAX_COLUMNS + 1);
	localparam logic [SLOT_W-1:0] RING_LAST = SLOT_W'(RING_DEPTH - 1);
	localparam logic [mpwa_pkg::HALF_W-1:0] EFF_H6 = mpwa_pkg::HALF_W'(EFF_MAX_H);

	// ------------------------------------------------------------------------
	// state
	// ------------------------------------------------------------------------
	mpwa_pkg::state_t state_q, state_d;

	logic [mpwa_pkg::HALF_W-1:0]  hw_q;        // configured half window
	logic [AH_W-1:0]              ah_q;        // half window of this sequence
	logic [CNT_W-1:0]             seen_q;      // columns of this sequence
	logic [CNT_W-1:0]             next_out_q;  // next column to send
	logic [SLOT_W-1:0]            wr_slot_q;   // ring slot of column seen_q

	logic [CNT_W-1:0]             col_q;       // column being averaged
	logic [CNT_W-1:0]             top_q;       // newest stored column
	logic [SLOT_W-1:0]            top_slot_q;  // its ring slot
	logic                         flush_q;     // working off the final column
	logic                         err_q;       // error word pending
	logic [AH_W-1:0]              res_cnt_q;   // flush words sent so far

	logic signed [XW-1:0]         x_q;         // tap position, may be negative
	logic [TAP_W-1:0]             tap_left_q;
	logic [SUM_W-1:0]             sum_q;       // window sum, then quotient
	logic [TAP_W-1:0]             rem_q;
	logic [DC_W-1:0]              div_cnt_q;

	logic                         vld_s1, vld_s2;
	logic [SLOT_W-1:0]            dist_s1;     // top column minus tap column
	logic [mpwa_pkg::SCORE_W-1:0] rd_s2;

	logic [mpwa_pkg::SCORE_W-1:0] ring_q [RING_DEPTH];

	logic                         out_valid_q;
	logic [mpwa_pkg::COLUMN_W-1:0] out_col_q;
	logic [mpwa_pkg::SCORE_W-1:0] out_avg_q;
	logic                         out_last_q;
	logic                         out_err_q;

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------
	logic                         in_ready, in_acc, first_col;
	logic [AH_W-1:0]              h_now;
	logic [SLOT_W-1:0]            slot_now;
	logic [mpwa_pkg::SCORE_W-1:0] score_sat;
	logic [CNT_W-1:0]             n_now;
	logic                         stored, emit_now, err_now;

	assign scores.ready = in_ready;
	assign in_acc       = scores.valid && in_ready;
	assign cfg.ready    = 1'b1;

	always_comb begin
		first_col = (seen_q == '0);
		if (first_col) begin
			h_now = (hw_q > EFF_H6) ? AH_W'(EFF_MAX_H) : hw_q[AH_W-1:0];
		end else begin
			h_now = ah_q;
		end
		slot_now  = first_col ? '0 : wr_slot_q;
		score_sat = (scores.score > mpwa_pkg::SCORE_ONE) ? mpwa_pkg::SCORE_ONE :
			scores.score;
		stored    = (seen_q < MAXC);
		n_now     = (seen_q <= MAXC) ? seen_q + 1'b1 : seen_q;
		emit_now  = stored && (seen_q >= CNT_W'(h_now));
		err_now   = (n_now > MAXC) || (CNT_W'(h_now) > (n_now >> mpwa_pkg::SPAN_SHIFT));
	end

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	logic out_load, more_cols;

	assign more_cols = flush_q && !err_q && (col_q != top_q) && (res_cnt_q != ah_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpwa_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (scores.final_column) begin
						state_d = err_now ? mpwa_pkg::ST_OUT : mpwa_pkg::ST_LOAD;
					end else if (emit_now) begin
						state_d = mpwa_pkg::ST_LOAD;
					end
				end
			end
			mpwa_pkg::ST_LOAD:  state_d = mpwa_pkg::ST_TAPS;
			mpwa_pkg::ST_TAPS: begin
				if (tap_left_q == TAP_W'(1)) begin
					state_d = mpwa_pkg::ST_DRAIN;
				end
			end
			mpwa_pkg::ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = mpwa_pkg::ST_DIV;
				end
			end
			mpwa_pkg::ST_DIV: begin
				if (div_cnt_q == DC_W'(1)) begin
					state_d = mpwa_pkg::ST_OUT;
				end
			end
			mpwa_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = more_cols ? mpwa_pkg::ST_LOAD : mpwa_pkg::ST_IDLE;
				end
			end
			default: state_d = mpwa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			mpwa_pkg::ST_IDLE: in_ready = 1'b1;
			mpwa_pkg::ST_OUT:  out_load = !out_valid_q || averages.ready;
			default: begin
				in_ready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------------
	// sequence bookkeeping
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q       <= '0;
			ah_q       <= '0;
			seen_q     <= '0;
			next_out_q <= '0;
			wr_slot_q  <= '0;
			flush_q    <= 1'b0;
			err_q      <= 1'b0;
			res_cnt_q  <= '0;
		end else begin
			if (cfg.valid) begin
				hw_q <= cfg.data;
			end
			if (in_acc) begin
				ah_q    <= h_now;
				flush_q <= scores.final_column;
				err_q   <= scores.final_column && err_now;
				res_cnt_q <= '0;
				if (stored) begin
					wr_slot_q <= (slot_now == RING_LAST) ? '0 : slot_now + 1'b1;
				end
				if (scores.final_column) begin
					seen_q     <= '0;
					next_out_q <= '0;
				end else begin
					seen_q <= n_now;
					if (emit_now) begin
						next_out_q <= seen_q - CNT_W'(h_now) + 1'b1;
					end
				end
			end else if (out_load && more_cols) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end
		end
	end

	// window centre and mirror reference; payload, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			top_q      <= seen_q;
			top_slot_q <= slot_now;
			col_q      <= scores.final_column ? next_out_q : seen_q - CNT_W'(h_now);
		end else if (out_load && more_cols) begin
			col_q <= col_q + 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// score ring
	// ------------------------------------------------------------------------
	logic [SLOT_W-1:0] rd_slot;
	logic [SLOT_W:0]   slot_wrap;

	always_ff @(posedge clk) begin
		if (in_acc && stored) begin
			ring_q[slot_now] <= score_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rd_s2 <= ring_q[rd_slot];
		end
	end

	// slot of tap column = top slot minus distance, modulo ring depth
	always_comb begin
		slot_wrap = {1'b0, top_slot_q} + (SLOT_W + 1)'(RING_DEPTH) - {1'b0, dist_s1};
		rd_slot   = (top_slot_q >= dist_s1) ? top_slot_q - dist_s1 : slot_wrap[SLOT_W-1:0];
	end

	// ------------------------------------------------------------------------
	// tap address stage: mirror about both ends, then clamp
	// ------------------------------------------------------------------------
	logic signed [XW-1:0] top_x, j_a, j_b, j_c;
	logic [SLOT_W-1:0]    dist_d;

	always_comb begin
		top_x  = $signed({2'b00, top_q});
		j_a    = (x_q < 0) ? -x_q : x_q;
		j_b    = (j_a > top_x) ? (top_x <<< 1) - j_a : j_a;
		j_c    = (j_b < 0) ? '0 : ((j_b > top_x) ? top_x : j_b);
		dist_d = SLOT_W'(top_x - j_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == mpwa_pkg::ST_TAPS);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mpwa_pkg::ST_TAPS) begin
			dist_s1 <= dist_d;
		end
	end

	// ------------------------------------------------------------------------
	// shared accumulate / restoring divide unit
	// ------------------------------------------------------------------------
	logic [TAP_W:0] rem_sh, divisor, rem_sub;
	logic           q_bit;

	always_comb begin
		divisor = {1'b0, ah_q, 1'b1};
		rem_sh  = {rem_q, sum_q[SUM_W-1]};
		q_bit   = (rem_sh >= divisor);
		rem_sub = q_bit ? rem_sh - divisor : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_left_q <= '0;
			div_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				mpwa_pkg::ST_LOAD:  tap_left_q <= {ah_q, 1'b1};
				mpwa_pkg::ST_TAPS:  tap_left_q <= tap_left_q - 1'b1;
				mpwa_pkg::ST_DRAIN: div_cnt_q  <= DC_W'(SUM_W);
				mpwa_pkg::ST_DIV:   div_cnt_q  <= div_cnt_q - 1'b1;
				default: begin
					tap_left_q <= tap_left_q;
					div_cnt_q  <= div_cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mpwa_pkg::ST_LOAD: begin
				x_q   <= $signed({2'b00, col_q}) - $signed(XW'(ah_q));
				sum_q <= '0;
			end
			mpwa_pkg::ST_TAPS, mpwa_pkg::ST_DRAIN: begin
				x_q <= x_q + 1'b1;
				if (vld_s2) begin
					sum_q <= sum_q + SUM_W'(rd_s2);
				end
				rem_q <= '0;
			end
			mpwa_pkg::ST_DIV: begin
				rem_q <= rem_sub[TAP_W-1:0];
				sum_q <= {sum_q[SUM_W-2:0], q_bit};
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (averages.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_col_q  <= err_q ? '0 : col_q[mpwa_pkg::COLUMN_W-1:0];
			out_avg_q  <= err_q ? '0 : sum_q[mpwa_pkg::SCORE_W-1:0];
			out_last_q <= err_q || (flush_q && (col_q == top_q));
			out_err_q  <= err_q;
		end
	end

	assign averages.valid   = out_valid_q;
	assign averages.column  = out_col_q;
	assign averages.average = out_avg_q;
	assign averages.last    = out_last_q;
	assign averages.error   = out_err_q;

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpwa_pkg::ST_IDLE) |-> (!vld_s1 && !vld_s2))
		else $error("tap pipe busy while idle");

	a_mean_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpwa_pkg::ST_OUT && !err_q) |->
			(sum_q <= SUM_W'(mpwa_pkg::SCORE_ONE)))
		else $error("mean above 1.0");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= MAXC_P1)
		else $error("column count past saturation");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (rd_slot <= RING_LAST))
		else $error("ring read slot out of range");

endmodule
